// ----- rtl/tspf_pkg.sv -----
// tspf_pkg: shared widths, constants and types for the two-sum pair finder
// no dependencies; used by tspf_hash and two_sum_pair_finder
package tspf_pkg;

    localparam int MAX_LENGTH_DEF  = 1024;
    localparam int TABLE_SLOTS_DEF = 2048;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 11;
    localparam int EPOCH_W = 8;

    localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;
    localparam int          HASH_LAT  = 4;
    localparam int          HCNT_W    = 3;

    typedef struct packed {
        logic [EPOCH_W-1:0] tag;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] value;
    } slot_t;

    typedef enum logic [6:0] {
        ST_CLEAR   = 7'b0000001,
        ST_IDLE    = 7'b0000010,
        ST_HASH    = 7'b0000100,
        ST_PROBE_A = 7'b0001000,
        ST_PROBE_B = 7'b0010000,
        ST_FINISH  = 7'b0100000,
        ST_SPARE   = 7'b1000000
    } state_t;

endpackage

// ----- rtl/tspf_hash.sv -----
// tspf_hash: four-stage pipelined home-slot hash (multiply, xor-shift, mod table size)
// depends on tspf_pkg; modulo uses a reciprocal multiply and one correction step
module tspf_hash
    import tspf_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
    parameter int SLOT_W      = $clog2(TABLE_SLOTS)
) (
    input  logic               aclk,
    input  logic [VALUE_W-1:0] key,
    output logic [SLOT_W-1:0]  home
);

    localparam logic [31:0]     RECIP = 32'((64'd1 << 32) / TABLE_SLOTS);
    localparam logic [SLOT_W:0] TS    = (SLOT_W + 1)'(TABLE_SLOTS);

    logic [31:0]        k1_reg, k1_next;
    logic [31:0]        k2_reg, k2_next;
    logic [31:0]        q_reg, q_next;
    logic [31:0]        k3_reg;
    logic [31:0]        qt_reg, qt_next;
    logic [SLOT_W-1:0]  home_reg, home_next;
    logic [63:0]        recip_prod;
    logic [32+SLOT_W:0] qt_full;
    logic [31:0]        diff;
    logic [SLOT_W:0]    rem;

    assign k1_next    = key * HASH_MULT;
    assign k2_next    = k1_reg ^ (k1_reg >> 16);
    assign recip_prod = {32'd0, k2_next} * {32'd0, RECIP};
    assign q_next     = recip_prod[63:32];
    assign qt_full    = {{(SLOT_W + 1){1'b0}}, q_reg} * {32'd0, TS};
    assign qt_next    = qt_full[31:0];
    assign diff       = k3_reg - qt_reg;
    assign rem        = diff[SLOT_W:0];
    assign home_next  = (rem >= TS) ? SLOT_W'(rem - TS) : rem[SLOT_W-1:0];

    always_ff @(posedge aclk) begin
        k1_reg   <= k1_next;
        k2_reg   <= k2_next;
        q_reg    <= q_next;
        k3_reg   <= k2_reg;
        qt_reg   <= qt_next;
        home_reg <= home_next;
    end

    assign home = home_reg;

endmodule

// ----- rtl/two_sum_pair_finder.sv -----
// two_sum_pair_finder: each item runs twice through the 4-stage hash, then probes the
// one registered-read table port for its complement (if in range) and, on a miss, for
// itself; items past the length limit or after a hit skip to finish. One item at a time.
// Reset (aresetn, synchronous) clears control state, then a clearing pass over all
// TABLE_SLOTS slots runs before the first transfer; the same pass recurs every 255 sequences.
// depends on tspf_pkg and tspf_hash
module two_sum_pair_finder
    import tspf_pkg::*;
#(
    parameter int MAX_LENGTH  = MAX_LENGTH_DEF,
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [VALUE_W-1:0] s_value,
    input  logic               s_is_last,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_found,
    output logic [POS_W-1:0]   m_first_position,
    output logic [POS_W-1:0]   m_second_position,
    output logic               m_overflow
);

    localparam int SLOT_W  = $clog2(TABLE_SLOTS);
    localparam int PROBE_W = $clog2(TABLE_SLOTS + 1);
    localparam int CNT_W   = $clog2(MAX_LENGTH + 1);

    state_t             state_reg, state_next;
    logic [31:0]        target_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pair_done_reg, pair_done_next;
    logic               ovf_seen_reg, ovf_seen_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [SLOT_W-1:0]  clr_reg, clr_next;
    logic [HCNT_W-1:0]  hcnt_reg, hcnt_next;

    logic [VALUE_W-1:0] value_reg, value_next;
    logic               last_reg, last_next;
    logic [VALUE_W:0]   want_reg, want_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               hit_reg, hit_next;
    logic [POS_W-1:0]   first_reg, first_next;
    logic [SLOT_W-1:0]  home_a_reg, home_a_next;
    logic [SLOT_W-1:0]  home_b_reg, home_b_next;
    logic [SLOT_W-1:0]  iss_reg, iss_next;
    logic [SLOT_W-1:0]  cmpa_reg, cmpa_next;
    logic               cmpv_reg, cmpv_next;
    logic [PROBE_W-1:0] probes_reg, probes_next;

    logic               m_valid_reg, m_valid_next;
    logic               m_found_reg, m_found_next;
    logic [POS_W-1:0]   m_first_reg, m_first_next;
    logic [POS_W-1:0]   m_second_reg, m_second_next;
    logic               m_ovf_reg, m_ovf_next;

    slot_t              mem [TABLE_SLOTS];
    slot_t              rd_reg;
    logic               we;
    logic [SLOT_W-1:0]  waddr;
    slot_t              wdata;

    logic [VALUE_W-1:0] hash_key;
    logic [SLOT_W-1:0]  hash_home;
    logic               in_range;
    logic [VALUE_W-1:0] cur_key;
    logic               slot_live;
    logic               slot_match;
    logic               last_probe;
    logic               emit;
    logic [SLOT_W-1:0]  iss_inc;
    logic [CNT_W-1:0]   count_inc;

    tspf_hash #(
        .TABLE_SLOTS(TABLE_SLOTS),
        .SLOT_W     (SLOT_W)
    ) u_hash (
        .aclk(aclk),
        .key (hash_key),
        .home(hash_home)
    );

    assign hash_key   = (hcnt_reg == '0) ? want_reg[VALUE_W-1:0] : value_reg;
    assign in_range   = (want_reg[VALUE_W] == want_reg[VALUE_W-1]);
    assign cur_key    = (state_reg == ST_PROBE_A) ? want_reg[VALUE_W-1:0] : value_reg;
    assign slot_live  = (rd_reg.tag == epoch_reg);
    assign slot_match = slot_live && (rd_reg.value == cur_key);
    assign last_probe = (probes_reg == PROBE_W'(TABLE_SLOTS - 1));
    assign emit       = hit_reg || (last_reg && !pair_done_reg);
    assign iss_inc    = (iss_reg == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : SLOT_W'(iss_reg + 1'b1);
    assign count_inc  = CNT_W'(count_reg + 1'b1);

    assign s_ready = (state_reg == ST_IDLE);

    // table memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[iss_reg];
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        pair_done_next = pair_done_reg;
        ovf_seen_next = ovf_seen_reg;
        epoch_next    = epoch_reg;
        clr_next      = clr_reg;
        hcnt_next     = hcnt_reg;
        value_next    = value_reg;
        last_next     = last_reg;
        want_next     = want_reg;
        pos_next      = pos_reg;
        hit_next      = hit_reg;
        first_next    = first_reg;
        home_a_next   = home_a_reg;
        home_b_next   = home_b_reg;
        iss_next      = iss_reg;
        cmpa_next     = cmpa_reg;
        cmpv_next     = cmpv_reg;
        probes_next   = probes_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_found_next  = m_found_reg;
        m_first_next  = m_first_reg;
        m_second_next = m_second_reg;
        m_ovf_next    = m_ovf_reg;
        we            = 1'b0;
        waddr         = clr_reg;
        wdata         = '{tag: '0, pos: pos_reg, value: value_reg};

        case (state_reg)
            ST_CLEAR: begin
                we       = 1'b1;
                clr_next = SLOT_W'(clr_reg + 1'b1);
                if (clr_reg == SLOT_W'(TABLE_SLOTS - 1)) begin
                    clr_next   = '0;
                    epoch_next = EPOCH_W'(1);
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    value_next = s_value;
                    last_next  = s_is_last;
                    want_next  = {target_reg[31], target_reg} - {s_value[VALUE_W-1], s_value};
                    hit_next   = 1'b0;
                    hcnt_next  = '0;
                    if (count_reg >= CNT_W'(MAX_LENGTH)) begin
                        ovf_seen_next = 1'b1;
                        state_next    = ST_FINISH;
                    end else begin
                        count_next = count_inc;
                        pos_next   = POS_W'(count_inc);
                        state_next = pair_done_reg ? ST_FINISH : ST_HASH;
                    end
                end
            end
            ST_HASH: begin
                hcnt_next = HCNT_W'(hcnt_reg + 1'b1);
                if (hcnt_reg == HCNT_W'(HASH_LAT)) begin
                    home_a_next = hash_home;
                end
                if (hcnt_reg == HCNT_W'(HASH_LAT + 1)) begin
                    home_b_next = hash_home;
                    iss_next    = in_range ? home_a_reg : hash_home;
                    cmpv_next   = 1'b0;
                    probes_next = '0;
                    state_next  = in_range ? ST_PROBE_A : ST_PROBE_B;
                end
            end
            ST_PROBE_A, ST_PROBE_B: begin
                // issue the next slot while checking the one read last cycle
                iss_next  = iss_inc;
                cmpa_next = iss_reg;
                cmpv_next = 1'b1;
                if (cmpv_reg) begin
                    if (slot_match) begin
                        if (state_reg == ST_PROBE_A) begin
                            hit_next       = 1'b1;
                            first_next     = rd_reg.pos;
                            pair_done_next = 1'b1;
                        end
                        state_next = ST_FINISH;
                    end else if (!slot_live || last_probe) begin
                        if (state_reg == ST_PROBE_A) begin
                            iss_next    = home_b_reg;
                            cmpv_next   = 1'b0;
                            probes_next = '0;
                            state_next  = ST_PROBE_B;
                        end else begin
                            if (!slot_live) begin
                                we    = 1'b1;
                                waddr = cmpa_reg;
                                wdata = '{tag: epoch_reg, pos: pos_reg, value: value_reg};
                            end else begin
                                ovf_seen_next = 1'b1;
                            end
                            state_next = ST_FINISH;
                        end
                    end else begin
                        probes_next = PROBE_W'(probes_reg + 1'b1);
                    end
                end
            end
            ST_FINISH: begin
                if (!(emit && m_valid_reg && !m_ready)) begin
                    if (emit) begin
                        m_valid_next  = 1'b1;
                        m_found_next  = hit_reg;
                        m_first_next  = hit_reg ? first_reg : '0;
                        m_second_next = hit_reg ? pos_reg : '0;
                        m_ovf_next    = ovf_seen_reg;
                    end
                    state_next = ST_IDLE;
                    if (last_reg) begin
                        count_next     = '0;
                        pair_done_next = 1'b0;
                        ovf_seen_next  = 1'b0;
                        // new epoch invalidates all slots; sweep when the tag wraps
                        if (epoch_reg == '1) begin
                            clr_next   = '0;
                            state_next = ST_CLEAR;
                        end else begin
                            epoch_next = EPOCH_W'(epoch_reg + 1'b1);
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            target_reg    <= '0;
            count_reg     <= '0;
            pair_done_reg <= 1'b0;
            ovf_seen_reg  <= 1'b0;
            epoch_reg     <= EPOCH_W'(1);
            clr_reg       <= '0;
            hcnt_reg      <= '0;
            hit_reg       <= 1'b0;
            cmpv_reg      <= 1'b0;
            probes_reg    <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            if (cfg_we) begin
                target_reg <= cfg_wdata;
            end
            count_reg     <= count_next;
            pair_done_reg <= pair_done_next;
            ovf_seen_reg  <= ovf_seen_next;
            epoch_reg     <= epoch_next;
            clr_reg       <= clr_next;
            hcnt_reg      <= hcnt_next;
            hit_reg       <= hit_next;
            cmpv_reg      <= cmpv_next;
            probes_reg    <= probes_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg    <= value_next;
        last_reg     <= last_next;
        want_reg     <= want_next;
        pos_reg      <= pos_next;
        first_reg    <= first_next;
        home_a_reg   <= home_a_next;
        home_b_reg   <= home_b_next;
        iss_reg      <= iss_next;
        cmpa_reg     <= cmpa_next;
        m_found_reg  <= m_found_next;
        m_first_reg  <= m_first_next;
        m_second_reg <= m_second_next;
        m_ovf_reg    <= m_ovf_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_found           = m_found_reg;
    assign m_first_position  = m_first_reg;
    assign m_second_position = m_second_reg;
    assign m_overflow        = m_ovf_reg;

endmodule

// ----- verif/tb_two_sum_pair_finder.sv -----
// tb_two_sum_pair_finder: self-checking testbench for the two-sum pair finder, with a
// tracking table model, directed and random sequences, idle and stall phases
// depends on tspf_pkg and two_sum_pair_finder
module tb_two_sum_pair_finder;
    import tspf_pkg::*;

    localparam int unsigned SLOTS     = TABLE_SLOTS_DEF;
    localparam int unsigned MAX_LEN   = MAX_LENGTH_DEF;
    localparam int          SETTLE    = 2300;
    localparam int          HOLD_LEN  = 400;
    localparam logic [31:0] INT_MIN   = 32'h8000_0000;
    localparam logic [31:0] INT_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] MINUS_ONE = 32'hFFFF_FFFF;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] first_pos;
        logic [POS_W-1:0] second_pos;
        logic             overflow;
    } pair_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [31:0]        cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [VALUE_W-1:0] s_value = '0;
    logic               s_is_last = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b1;
    logic               m_found;
    logic [POS_W-1:0]   m_first_position;
    logic [POS_W-1:0]   m_second_position;
    logic               m_overflow;

    // tracking copy of the pair search
    logic [31:0]      sum_goal = '0;
    logic [31:0]      tbl_value [SLOTS];
    logic [POS_W-1:0] tbl_pos [SLOTS];
    logic [SLOTS-1:0] tbl_used = '0;
    int unsigned      item_count = 0;
    bit               pair_seen = 1'b0;
    bit               length_exceeded = 1'b0;

    pair_result_t pair_result_q[$];
    int           error_count = 0;
    int           items_sent = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           hold_requests = 0;
    int           holds_served = 0;
    int           hold_left = 0;

    two_sum_pair_finder dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_value           (s_value),
        .s_is_last         (s_is_last),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_found           (m_found),
        .m_first_position  (m_first_position),
        .m_second_position (m_second_position),
        .m_overflow        (m_overflow)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int unsigned home_of(input logic [31:0] key);
        logic [31:0] k;
        k = key * 32'd2654435761;
        k = k ^ (k >> 16);
        return k % SLOTS;
    endfunction

    function automatic int unsigned lookup_slot(input logic [31:0] key,
                                                output int unsigned free_at);
        int unsigned s;
        int unsigned n;
        s = home_of(key);
        free_at = SLOTS;
        for (n = 0; n < SLOTS; n++) begin
            if (!tbl_used[s]) begin
                free_at = s;
                return SLOTS;
            end
            if (tbl_value[s] == key) return s;
            s = (s + 1 == SLOTS) ? 0 : s + 1;
        end
        return SLOTS;
    endfunction

    function automatic logic [31:0] value_with_home(input int unsigned home);
        logic [31:0] v;
        v = $urandom;
        while (home_of(v) != home) v = $urandom;
        return v;
    endfunction

    task automatic predict_pair_result(input logic [31:0] v, input logic last);
        logic signed [32:0] want;
        int unsigned        hit;
        int unsigned        free_at;
        pair_result_t       r;
        bit                 emitted;
        emitted = 1'b0;
        hit = SLOTS;
        if (item_count >= MAX_LEN) begin
            length_exceeded = 1'b1;
        end else begin
            item_count++;
            if (!pair_seen) begin
                want = $signed({sum_goal[31], sum_goal}) - $signed({v[31], v});
                if (want[32] == want[31]) hit = lookup_slot(want[31:0], free_at);
                if (hit < SLOTS) begin
                    pair_seen = 1'b1;
                    r.found = 1'b1;
                    r.first_pos = tbl_pos[hit];
                    r.second_pos = item_count[POS_W-1:0];
                    r.overflow = length_exceeded;
                    pair_result_q.insert(pair_result_q.size(), r);
                    emitted = 1'b1;
                end else if (lookup_slot(v, free_at) == SLOTS) begin
                    if (free_at < SLOTS) begin
                        tbl_value[free_at] = v;
                        tbl_pos[free_at] = item_count[POS_W-1:0];
                        tbl_used[free_at] = 1'b1;
                    end else begin
                        length_exceeded = 1'b1;
                    end
                end
            end
        end
        if (last) begin
            if (!emitted && !pair_seen) begin
                r = '0;
                r.overflow = length_exceeded;
                pair_result_q.insert(pair_result_q.size(), r);
            end
            tbl_used = '0;
            item_count = 0;
            pair_seen = 1'b0;
            length_exceeded = 1'b0;
        end
    endtask

    // entered and left at a falling edge; valid stays high between back-to-back items
    task automatic send_item(input logic [31:0] v, input logic last);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_value <= v;
        s_is_last <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_pair_result(v, last);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_block_idle();
        s_valid <= 1'b0;
        while (pair_result_q.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_target(input logic [31:0] goal);
        wait_block_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= goal;
        @(negedge aclk);
        cfg_we <= 1'b0;
        sum_goal = goal;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s: got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    task automatic send_random_sequence(input int len);
        logic [31:0]        seen_vals[$];
        logic [31:0]        v;
        logic [31:0]        u;
        logic signed [32:0] dif;
        int                 pick;
        int                 pv;
        int                 i;
        for (i = 0; i < len; i++) begin
            pick = $urandom_range(99);
            pv = $urandom_range(16);
            if (pick < 15 && seen_vals.size() > 0) begin
                u = seen_vals[$urandom_range(seen_vals.size() - 1)];
                dif = $signed({sum_goal[31], sum_goal}) - $signed({u[31], u});
                v = (dif[32] == dif[31]) ? dif[31:0] : $urandom;
            end else if (pick < 30) begin
                v = pv - 8;
            end else if (pick < 40) begin
                v = sum_goal - (pv - 8);
            end else if (pick < 50) begin
                case ($urandom_range(3))
                    0: v = INT_MIN;
                    1: v = INT_MAX;
                    2: v = '0;
                    default: v = MINUS_ONE;
                endcase
            end else begin
                v = $urandom;
            end
            seen_vals.insert(seen_vals.size(), v);
            send_item(v, i == len - 1);
        end
    endtask

    task automatic run_random_phase(input logic [31:0] goal, input int idle_pct,
                                    input int stall_pct, input int n_items);
        int stop_at;
        write_target(goal);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(9) == 0) send_random_sequence($urandom_range(9, 120));
            else send_random_sequence($urandom_range(1, 8));
        end
    endtask

    task automatic test_basic_pairs();
        write_target('0);
        send_item(32'd5, 1'b0);
        send_item(-32'sd5, 1'b1);
        send_item(32'd7, 1'b1);
        // no self match on a lone zero
        send_item('0, 1'b1);
        // first position of a repeated value is kept
        send_item(32'd3, 1'b0);
        send_item(32'd3, 1'b0);
        send_item(32'd3, 1'b0);
        send_item(-32'sd3, 1'b1);
        // items after a hit are ignored, last one included
        send_item(32'd1, 1'b0);
        send_item(MINUS_ONE, 1'b0);
        send_item(32'd9, 1'b0);
        send_item(-32'sd9, 1'b1);
    endtask

    task automatic test_field_extremes();
        // complements outside the signed range never match; in-range pairs at the extremes still do
        write_target(INT_MAX);
        send_item(INT_MIN, 1'b0);
        send_item(MINUS_ONE, 1'b0);
        send_item(INT_MAX, 1'b0);
        send_item('0, 1'b1);
        write_target(INT_MIN);
        send_item(32'd1, 1'b0);
        send_item(INT_MAX, 1'b0);
        send_item(INT_MIN, 1'b0);
        send_item('0, 1'b1);
        write_target(MINUS_ONE);
        send_item(INT_MIN, 1'b0);
        send_item(INT_MAX, 1'b1);
    endtask

    task automatic test_probe_wraparound();
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        // three values land on the top slot, one on slot zero
        a = value_with_home(SLOTS - 1);
        b = value_with_home(SLOTS - 1);
        while (b == a) b = value_with_home(SLOTS - 1);
        c = value_with_home(SLOTS - 1);
        while (c == a || c == b) c = value_with_home(SLOTS - 1);
        d = value_with_home(0);
        write_target(MINUS_ONE);
        send_item(a, 1'b0);
        send_item(b, 1'b0);
        send_item(c, 1'b0);
        send_item(d, 1'b0);
        send_item(MINUS_ONE - c, 1'b1);
    endtask

    task automatic test_random_traffic();
        int pv;
        pv = $urandom_range(32);
        run_random_phase('0, 0, 0, 150);
        run_random_phase(INT_MAX, 80, 0, 150);
        run_random_phase(pv - 16, 0, 80, 150);
        run_random_phase(INT_MIN, 21, 21, 150);
        run_random_phase($urandom, 0, 0, 150);
    endtask

    task automatic test_result_backpressure();
        int i;
        write_target(32'd6);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_requests++;
        for (i = 0; i < 60; i++) send_item($urandom, 1'b1);
    endtask

    task automatic test_length_overflow();
        int i;
        write_target($urandom);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (i = 0; i < MAX_LEN + 2; i++) send_item($urandom, i == MAX_LEN + 1);
    endtask

    // receiver side, with an occasional long hold-off
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_left == 0 && holds_served < hold_requests) begin
                holds_served++;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        pair_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pair_result_q.size() == 0) begin
                report_mismatch("unexpected result", 32'({m_found, m_first_position,
                                m_second_position, m_overflow}), 32'd0);
            end else begin
                e = pair_result_q.pop_front();
                if (m_found !== e.found)
                    report_mismatch("found", 32'(m_found), 32'(e.found));
                if (m_first_position !== e.first_pos)
                    report_mismatch("first_position", 32'(m_first_position),
                                    32'(e.first_pos));
                if (m_second_position !== e.second_pos)
                    report_mismatch("second_position", 32'(m_second_position),
                                    32'(e.second_pos));
                if (m_overflow !== e.overflow)
                    report_mismatch("overflow", 32'(m_overflow), 32'(e.overflow));
            end
        end
    end

    initial begin
        #8_000_000;
        $display("two_sum_pair_finder test failed");
        $finish;
    end

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_basic_pairs();
        test_field_extremes();
        test_probe_wraparound();
        test_random_traffic();
        test_result_backpressure();
        test_length_overflow();
        wait_block_idle();
        if (error_count == 0) begin
            $display("two_sum_pair_finder test passed");
        end else begin
            $display("two_sum_pair_finder test failed");
        end
        $finish;
    end

endmodule
